@@ src/sscs_pkg.sv @@
// sscs_pkg: shared types, constants and the segment lookup for the
// seven-segment clock scanner. No dependencies.
package sscs_pkg;

  localparam int SEG_W   = 8;
  localparam int POS_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;
  localparam int RPM_W   = 16;
  localparam int DINT_W  = 8;

  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [CIDX_W-1:0]  cfg_idx_t;
  typedef logic [CDATA_W-1:0] cfg_data_t;

  // configuration register indexes
  localparam cfg_idx_t REG_START_HOUR_TENS    = 3'd0;
  localparam cfg_idx_t REG_START_HOUR_UNITS   = 3'd1;
  localparam cfg_idx_t REG_START_MINUTE_TENS  = 3'd2;
  localparam cfg_idx_t REG_START_MINUTE_UNITS = 3'd3;
  localparam cfg_idx_t REG_REFRESHES          = 3'd4;
  localparam cfg_idx_t REG_DOT_INTERVAL       = 3'd5;

  // scan slots within one refresh pass
  localparam slot_t SLOT_MIN_UNITS  = 4'd0;
  localparam slot_t SLOT_MIN_TENS   = 4'd2;
  localparam slot_t SLOT_HOUR_UNITS = 4'd4;
  localparam slot_t SLOT_HOUR_TENS  = 4'd6;
  localparam slot_t SLOT_LAST_DIGIT = 4'd7;
  localparam slot_t SLOT_DOTS       = 4'd8;
  localparam slot_t SLOT_LAST       = 4'd9;

  localparam pos_t POS_HOUR_TENS  = 2'd0;
  localparam pos_t POS_HOUR_UNITS = 2'd1;
  localparam pos_t POS_MIN_TENS   = 2'd2;
  localparam pos_t POS_MIN_UNITS  = 2'd3;

  localparam seg_t DOTS_SEG  = 8'h03;
  localparam seg_t BLANK_SEG = 8'h00;

  localparam logic [RPM_W-1:0]  RPM_RESET  = 16'd3000;
  localparam logic [DINT_W-1:0] DINT_RESET = 8'd25;

  function automatic seg_t seg_lookup(input logic [3:0] digit);
    seg_t s;
    unique case (digit)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      4'hF: s = 8'h71;
      default: s = BLANK_SEG;
    endcase
    return s;
  endfunction

endpackage

@@ src/seven_segment_clock_scanner.sv @@
// seven_segment_clock_scanner: four-digit multiplexed clock display scanner.
// Depends on sscs_pkg for constants and the segment lookup.
//
// Usage: every item on the in_ channel is one scan slot. in_tick=1 steps to
// the next slot, in_tick=0 repeats the current slot. Each item yields exactly
// one result on the out_ channel: segment pattern, digit position, lit flag
// and colon-dots flag. A pass scans minute units, minute tens, hour units and
// hour tens, each followed by a blank slot, plus a dots slot and a blank slot
// on every dot_interval-th pass. After refreshes_per_minute passes the time
// advances one minute, wrapping 23:59 to 00:00.
// Results are registered: out_valid rises in the cycle after acceptance; one
// item per cycle while out_ready is high, set by the single result register.
// The result register frees up in the cycle it is taken, so in_ready stays
// high while out_ready is high; when the receiver stalls with a result held,
// in_ready drops until it is taken.
// Reset (synchronous, active low) sets the time to 15:41, the scan to the
// minute-units slot and the limits to 3000 passes and a dot interval of 25.
// Writes to the start registers load the time digits directly.
module seven_segment_clock_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_tick,
  output logic                out_valid,
  input  logic                out_ready,
  output sscs_pkg::seg_t      out_segments,
  output sscs_pkg::pos_t      out_position,
  output logic                out_lit,
  output logic                out_dots,
  input  logic                cfg_we,
  input  sscs_pkg::cfg_idx_t  cfg_index,
  input  sscs_pkg::cfg_data_t cfg_wdata
);
  import sscs_pkg::*;

  logic [1:0]        hour_tens_r, hour_tens_nxt;
  logic [3:0]        hour_units_r, hour_units_nxt;
  logic [2:0]        min_tens_r, min_tens_nxt;
  logic [3:0]        min_units_r, min_units_nxt;
  slot_t             slot_r, slot_nxt;
  logic [RPM_W-1:0]  refresh_cnt_r, refresh_cnt_nxt;
  logic [DINT_W-1:0] dot_cnt_r, dot_cnt_nxt;
  logic [RPM_W-1:0]  rpm_r, rpm_nxt;
  logic [DINT_W-1:0] dint_r, dint_nxt;

  logic              out_valid_r, out_valid_nxt;
  seg_t              out_seg_r, out_seg_nxt;
  pos_t              out_pos_r, out_pos_nxt;
  logic              out_lit_r, out_lit_nxt;
  logic              out_dots_r, out_dots_nxt;

  logic              in_fire;
  logic [RPM_W-1:0]  rpm_lim;
  logic [DINT_W-1:0] dint_lim;
  logic [RPM_W:0]    refresh_inc;
  logic [DINT_W:0]   dot_inc;
  logic [4:0]        min_units_inc;
  logic [3:0]        min_tens_inc;
  logic [4:0]        hour_units_inc;

  assign in_ready     = !out_valid_r || out_ready;
  assign in_fire      = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_segments = out_seg_r;
  assign out_position = out_pos_r;
  assign out_lit      = out_lit_r;
  assign out_dots     = out_dots_r;

  // zero limits behave as one
  assign rpm_lim  = (rpm_r == '0) ? RPM_W'(1) : rpm_r;
  assign dint_lim = (dint_r == '0) ? DINT_W'(1) : dint_r;

  assign refresh_inc    = {1'b0, refresh_cnt_r} + (RPM_W+1)'(1);
  assign dot_inc        = {1'b0, dot_cnt_r} + (DINT_W+1)'(1);
  assign min_units_inc  = {1'b0, min_units_r} + 5'd1;
  assign min_tens_inc   = {1'b0, min_tens_r} + 4'd1;
  assign hour_units_inc = {1'b0, hour_units_r} + 5'd1;

  always_comb begin
    logic end_pass;
    hour_tens_nxt   = hour_tens_r;
    hour_units_nxt  = hour_units_r;
    min_tens_nxt    = min_tens_r;
    min_units_nxt   = min_units_r;
    slot_nxt        = slot_r;
    refresh_cnt_nxt = refresh_cnt_r;
    dot_cnt_nxt     = dot_cnt_r;
    rpm_nxt         = rpm_r;
    dint_nxt        = dint_r;
    end_pass        = 1'b0;

    priority if (cfg_we) begin
      unique case (cfg_index)
        REG_START_HOUR_TENS:    hour_tens_nxt  = cfg_wdata[1:0];
        REG_START_HOUR_UNITS:   hour_units_nxt = cfg_wdata[3:0];
        REG_START_MINUTE_TENS:  min_tens_nxt   = cfg_wdata[2:0];
        REG_START_MINUTE_UNITS: min_units_nxt  = cfg_wdata[3:0];
        REG_REFRESHES:          rpm_nxt        = cfg_wdata[RPM_W-1:0];
        REG_DOT_INTERVAL:       dint_nxt       = cfg_wdata[DINT_W-1:0];
        default: ;
      endcase
    end else if (in_fire && in_tick) begin
      priority if (slot_r == SLOT_LAST_DIGIT) begin
        if (dot_cnt_r == '0) begin
          slot_nxt = SLOT_DOTS;
        end else begin
          end_pass = 1'b1;
        end
      end else if (slot_r >= SLOT_LAST) begin
        end_pass = 1'b1;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end

      if (end_pass) begin
        slot_nxt = SLOT_MIN_UNITS;
        if (refresh_inc >= {1'b0, rpm_lim}) begin
          refresh_cnt_nxt = '0;
          dot_cnt_nxt     = '0;
          // minute advance, carries use >= so oversized digits roll over
          if (min_units_inc < 5'd10) begin
            min_units_nxt = min_units_inc[3:0];
          end else begin
            min_units_nxt = '0;
            if (min_tens_inc < 4'd6) begin
              min_tens_nxt = min_tens_inc[2:0];
            end else begin
              min_tens_nxt = '0;
              priority if (hour_tens_r >= 2'd2 && hour_units_inc >= 5'd4) begin
                hour_tens_nxt  = '0;
                hour_units_nxt = '0;
              end else if (hour_units_inc >= 5'd10) begin
                hour_units_nxt = '0;
                hour_tens_nxt  = hour_tens_r + 2'd1;
              end else begin
                hour_units_nxt = hour_units_inc[3:0];
              end
            end
          end
        end else begin
          refresh_cnt_nxt = refresh_inc[RPM_W-1:0];
          dot_cnt_nxt     = (dot_inc >= {1'b0, dint_lim}) ? '0 : dot_inc[DINT_W-1:0];
        end
      end
    end else begin
    end
  end

  // result decode from the post-step state
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_seg_nxt   = out_seg_r;
    out_pos_nxt   = out_pos_r;
    out_lit_nxt   = out_lit_r;
    out_dots_nxt  = out_dots_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_seg_nxt   = BLANK_SEG;
      out_pos_nxt   = POS_HOUR_TENS;
      out_lit_nxt   = 1'b0;
      out_dots_nxt  = 1'b0;
      unique case (slot_nxt)
        SLOT_MIN_UNITS: begin
          out_seg_nxt = seg_lookup(min_units_nxt);
          out_pos_nxt = POS_MIN_UNITS;
          out_lit_nxt = 1'b1;
        end
        SLOT_MIN_TENS: begin
          out_seg_nxt = seg_lookup({1'b0, min_tens_nxt});
          out_pos_nxt = POS_MIN_TENS;
          out_lit_nxt = 1'b1;
        end
        SLOT_HOUR_UNITS: begin
          out_seg_nxt = seg_lookup(hour_units_nxt);
          out_pos_nxt = POS_HOUR_UNITS;
          out_lit_nxt = 1'b1;
        end
        SLOT_HOUR_TENS: begin
          out_seg_nxt = seg_lookup({2'b00, hour_tens_nxt});
          out_pos_nxt = POS_HOUR_TENS;
          out_lit_nxt = 1'b1;
        end
        SLOT_DOTS: begin
          out_seg_nxt  = DOTS_SEG;
          out_dots_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_tens_r   <= 2'd1;
      hour_units_r  <= 4'd5;
      min_tens_r    <= 3'd4;
      min_units_r   <= 4'd1;
      slot_r        <= SLOT_MIN_UNITS;
      refresh_cnt_r <= '0;
      dot_cnt_r     <= '0;
      rpm_r         <= RPM_RESET;
      dint_r        <= DINT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      hour_tens_r   <= hour_tens_nxt;
      hour_units_r  <= hour_units_nxt;
      min_tens_r    <= min_tens_nxt;
      min_units_r   <= min_units_nxt;
      slot_r        <= slot_nxt;
      refresh_cnt_r <= refresh_cnt_nxt;
      dot_cnt_r     <= dot_cnt_nxt;
      rpm_r         <= rpm_nxt;
      dint_r        <= dint_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_seg_r  <= out_seg_nxt;
    out_pos_r  <= out_pos_nxt;
    out_lit_r  <= out_lit_nxt;
    out_dots_r <= out_dots_nxt;
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_LAST)
    else $error("scan slot out of range");

  a_hold_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tick |=> $stable(slot_r))
    else $error("slot moved on a repeat item");

  a_lit_dots_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_lit_r && out_dots_r))
    else $error("digit and dots slot at once");

  a_dots_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dots_r |-> out_seg_r == DOTS_SEG && out_pos_r == POS_HOUR_TENS)
    else $error("dots slot with wrong pattern");
`endif

endmodule

@@ test/testbench.sv @@
// Testbench for seven_segment_clock_scanner: random bursts of scan items with
// receiver back-pressure, checked against an in-bench clock/scan predictor.
// Depends on sscs_pkg and the scanner RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sscs_pkg::*;

  // indexes past the last register, writes there must change nothing
  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 48;

  typedef struct packed {
    seg_t seg;
    pos_t pos;
    logic lit;
    logic dots;
  } slot_view_t;

  class scan_scoreboard;
    logic [1:0]  hour_tens;
    logic [3:0]  hour_units;
    logic [2:0]  minute_tens;
    logic [3:0]  minute_units;
    slot_t       slot;
    logic [15:0] pass_count;
    logic [15:0] pass_limit;
    logic [7:0]  dot_count;
    logic [7:0]  dot_every;
    slot_view_t  expected_slots[$];
    int unsigned errors;
    int unsigned ticks_noted;
    int unsigned slots_checked;
    int unsigned minute_carries;
    int unsigned colon_slots;

    function new();
      errors = 0;
      ticks_noted = 0;
      slots_checked = 0;
      minute_carries = 0;
      colon_slots = 0;
      hour_tens = 2'd1;
      hour_units = 4'd5;
      minute_tens = 3'd4;
      minute_units = 4'd1;
      slot = SLOT_MIN_UNITS;
      pass_count = '0;
      dot_count = '0;
      pass_limit = RPM_RESET;
      dot_every = DINT_RESET;
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    function seg_t digit_glyph(logic [3:0] d);
      case (d)
        4'h0: return 8'h3F;
        4'h1: return 8'h06;
        4'h2: return 8'h5B;
        4'h3: return 8'h4F;
        4'h4: return 8'h66;
        4'h5: return 8'h6D;
        4'h6: return 8'h7D;
        4'h7: return 8'h07;
        4'h8: return 8'h7F;
        4'h9: return 8'h6F;
        4'hA: return 8'h77;
        4'hB: return 8'h7C;
        4'hC: return 8'h39;
        4'hD: return 8'h5E;
        4'hE: return 8'h79;
        default: return 8'h71;
      endcase
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t val);
      case (idx)
        REG_START_HOUR_TENS:    hour_tens = val[1:0];
        REG_START_HOUR_UNITS:   hour_units = val[3:0];
        REG_START_MINUTE_TENS:  minute_tens = val[2:0];
        REG_START_MINUTE_UNITS: minute_units = val[3:0];
        REG_REFRESHES:          pass_limit = val[15:0];
        REG_DOT_INTERVAL:       dot_every = val[7:0];
        default: ;
      endcase
    endfunction

    // carry tests compare the digit before incrementing, so oversized digits carry
    function void step_minute();
      minute_carries++;
      if (minute_units < 4'd9) begin
        minute_units = minute_units + 4'd1;
        return;
      end
      minute_units = '0;
      if (minute_tens < 3'd5) begin
        minute_tens = minute_tens + 3'd1;
        return;
      end
      minute_tens = '0;
      if (hour_tens >= 2'd2 && hour_units >= 4'd3) begin
        hour_tens = '0;
        hour_units = '0;
        return;
      end
      if (hour_units >= 4'd9) begin
        hour_units = '0;
        hour_tens = hour_tens + 2'd1;
      end else begin
        hour_units = hour_units + 4'd1;
      end
    endfunction

    function void end_pass();
      logic [16:0] pass_next;
      logic [8:0]  dot_next;
      logic [15:0] lim;
      logic [7:0]  dlim;
      lim = (pass_limit == '0) ? 16'd1 : pass_limit;
      dlim = (dot_every == '0) ? 8'd1 : dot_every;
      slot = SLOT_MIN_UNITS;
      pass_next = {1'b0, pass_count} + 17'd1;
      if (pass_next >= {1'b0, lim}) begin
        pass_count = '0;
        dot_count = '0;
        step_minute();
      end else begin
        pass_count = pass_next[15:0];
        dot_next = {1'b0, dot_count} + 9'd1;
        dot_count = (dot_next >= {1'b0, dlim}) ? 8'd0 : dot_next[7:0];
      end
    endfunction

    function void note_tick(logic tick);
      slot_view_t v;
      if (tick) begin
        if (slot == SLOT_LAST_DIGIT) begin
          if (dot_count == '0) slot = SLOT_DOTS;
          else end_pass();
        end else if (slot >= SLOT_LAST) begin
          end_pass();
        end else begin
          slot = slot + SLOT_W'(1);
        end
      end
      // blank slots report position zero
      v.seg = BLANK_SEG;
      v.pos = POS_HOUR_TENS;
      v.lit = 1'b0;
      v.dots = 1'b0;
      case (slot)
        SLOT_MIN_UNITS: begin
          v.seg = digit_glyph(minute_units);
          v.pos = POS_MIN_UNITS;
          v.lit = 1'b1;
        end
        SLOT_MIN_TENS: begin
          v.seg = digit_glyph({1'b0, minute_tens});
          v.pos = POS_MIN_TENS;
          v.lit = 1'b1;
        end
        SLOT_HOUR_UNITS: begin
          v.seg = digit_glyph(hour_units);
          v.pos = POS_HOUR_UNITS;
          v.lit = 1'b1;
        end
        SLOT_HOUR_TENS: begin
          v.seg = digit_glyph({2'b00, hour_tens});
          v.pos = POS_HOUR_TENS;
          v.lit = 1'b1;
        end
        SLOT_DOTS: begin
          v.seg = DOTS_SEG;
          v.dots = 1'b1;
          colon_slots++;
        end
        default: ;
      endcase
      expected_slots.push_back(v);
      ticks_noted++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_slot(seg_t seg, pos_t pos, logic lit, logic dots);
      slot_view_t e;
      if (expected_slots.size() == 0) begin
        report($sformatf("result with nothing expected: seg %h pos %0d lit %b dots %b",
                         seg, pos, lit, dots));
        return;
      end
      e = expected_slots.pop_front();
      slots_checked++;
      if (seg !== e.seg || pos !== e.pos || lit !== e.lit || dots !== e.dots)
        report($sformatf({"item %0d: got seg %h pos %0d lit %b dots %b, ",
                          "want seg %h pos %0d lit %b dots %b"},
                         slots_checked, seg, pos, lit, dots, e.seg, e.pos, e.lit, e.dots));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  logic      in_tick;
  logic      out_valid;
  logic      out_ready;
  seg_t      out_segments;
  pos_t      out_position;
  logic      out_lit;
  logic      out_dots;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  scan_scoreboard sb;
  bit          hold_request;
  int unsigned long_holds;
  int unsigned cfg_writes;

  seven_segment_clock_scanner dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_tick      (in_tick),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_segments (out_segments),
    .out_position (out_position),
    .out_lit      (out_lit),
    .out_dots     (out_dots),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #200000;
    $display("timeout: %0d items still expected", sb.pending());
    $display("seven_segment_clock_scanner test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_slot(out_segments, out_position, out_lit, out_dots);
  end

  // receiver: alternating ready and stall runs, plus one long hold on request
  initial begin : receiver
    int  left;
    bit  taking;
    left = 0;
    taking = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        long_holds++;
      end else begin
        if (left == 0) begin
          taking = !taking;
          if (taking)
            left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
          else
            left = $urandom_range(1, 4);
        end
        out_ready = taking;
        left--;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input logic t);
    in_valid = 1'b1;
    in_tick = t;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // time digits lean toward carry points, limits toward tiny values and extremes
  function automatic cfg_data_t pick_value(cfg_idx_t idx);
    cfg_data_t v;
    case (idx)
      REG_START_HOUR_TENS:   v = 16'($urandom_range(0, 3));
      REG_START_HOUR_UNITS: begin
        case ($urandom_range(0, 3))
          0: v = 16'd3;
          1: v = 16'd9;
          default: v = 16'($urandom_range(0, 15));
        endcase
      end
      REG_START_MINUTE_TENS:  v = $urandom_range(0, 1) ? 16'd5 : 16'($urandom_range(0, 7));
      REG_START_MINUTE_UNITS: v = $urandom_range(0, 1) ? 16'd9 : 16'($urandom_range(0, 15));
      REG_REFRESHES: begin
        case ($urandom_range(0, 9))
          0: v = 16'd0;
          1: v = 16'hFFFF;
          2: v = 16'($urandom_range(0, 16'hFFFF));
          default: v = 16'($urandom_range(1, 4));
        endcase
      end
      default: begin
        case ($urandom_range(0, 9))
          0: v = 16'd0;
          1: v = 16'd255;
          2: v = 16'($urandom_range(0, 255));
          default: v = 16'($urandom_range(1, 4));
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic configure_phase(input int phase);
    case (phase)
      0: begin
        for (int r = REG_START_HOUR_TENS; r <= REG_START_MINUTE_UNITS; r++)
          write_cfg(cfg_idx_t'(r), pick_value(cfg_idx_t'(r)));
        write_cfg(REG_REFRESHES, 16'hFFFF);
        write_cfg(REG_DOT_INTERVAL, 16'd255);
      end
      // pass counter is now beyond the new limit
      1: write_cfg(REG_REFRESHES, 16'd1);
      2: begin
        write_cfg(REG_REFRESHES, 16'd2);
        write_cfg(REG_DOT_INTERVAL, 16'd3);
      end
      default: begin
        for (int r = REG_START_HOUR_TENS; r <= REG_DOT_INTERVAL; r++)
          if ($urandom_range(0, 1)) write_cfg(cfg_idx_t'(r), pick_value(cfg_idx_t'(r)));
      end
    endcase
  endtask

  task automatic run_phase(input int n);
    int  sent;
    int  gap;
    int  burst;
    bit  no_gaps;
    sent = 0;
    no_gaps = ($urandom_range(0, 3) == 0);
    while (sent < n) begin
      burst = no_gaps ? n : $urandom_range(1, 12);
      while (burst > 0 && sent < n) begin
        send_tick($urandom_range(0, 4) != 0);
        sent++;
        burst--;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid = 1'b0;
  endtask

  initial begin : stimulus
    int n;
    int phase;
    int random_items;
    int w;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_tick = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_START_HOUR_TENS;
    cfg_wdata = '0;
    hold_request = 1'b0;
    long_holds = 0;
    cfg_writes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, repeat and step
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // 23:59 with one pass per minute and dots on every pass
    write_cfg(REG_START_HOUR_TENS, 16'd2);
    write_cfg(REG_START_HOUR_UNITS, 16'd3);
    write_cfg(REG_START_MINUTE_TENS, 16'd5);
    write_cfg(REG_START_MINUTE_UNITS, 16'd9);
    write_cfg(REG_REFRESHES, 16'd1);
    write_cfg(REG_DOT_INTERVAL, 16'd1);
    repeat (12) send_tick(1'b1);
    settle();

    // unused indexes, zero limits and oversized digits shown as hex glyphs
    write_cfg(REG_SPARE_LO, 16'hFFFF);
    write_cfg(REG_SPARE_HI, 16'h5A5A);
    write_cfg(REG_REFRESHES, 16'd0);
    write_cfg(REG_DOT_INTERVAL, 16'd0);
    write_cfg(REG_START_HOUR_TENS, 16'd3);
    write_cfg(REG_START_HOUR_UNITS, 16'd15);
    write_cfg(REG_START_MINUTE_TENS, 16'd7);
    write_cfg(REG_START_MINUTE_UNITS, 16'd15);
    repeat (9) send_tick(1'b1);
    send_tick(1'b0);
    settle();

    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      n = $urandom_range(20, 60);
      configure_phase(phase);
      // receiver holds off while the sender keeps offering
      if (phase == 3) hold_request = 1'b1;
      run_phase(n);
      random_items += n;
      settle();
      phase++;
    end

    for (w = 0; w < 1000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected items never came out", sb.pending()));

    $display("covered %0d scan items over %0d phases with %0d register writes",
             sb.ticks_noted, phase, cfg_writes);
    $display("predicted %0d minute advances and %0d colon slots, %0d long receiver holds",
             sb.minute_carries, sb.colon_slots, long_holds);
    if (sb.errors == 0) begin
      $display("seven_segment_clock_scanner test passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("seven_segment_clock_scanner test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sscs_pkg.sv
src/seven_segment_clock_scanner.sv
test/testbench.sv
